FILE: rtl/nws_pkg.sv
`default_nettype none

package nws_pkg;

    localparam int PIX_W     = 16;
    localparam int MAX_WIDTH = 32;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WCFG_W    = 6;
    localparam int WGT_W     = 16;
    localparam int FRAC_W    = 16;

    // sum of four pixels, then times an unsigned weight
    localparam int SUM_W  = PIX_W + 2;
    localparam int PROD_W = SUM_W + WGT_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    typedef logic signed [PIX_W-1:0] pix_t;
    typedef pix_t win_t [3][3];

    // filter position inside the 4x4 patch: row 1 or 2, column 1 or 2
    typedef enum logic [1:0] {
        POS_PREV_LEFT = 2'b00,
        POS_PREV_HERE = 2'b01,
        POS_CUR_LEFT  = 2'b10,
        POS_CUR_HERE  = 2'b11
    } pos_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_CORNER = 2'd2,
        REG_EDGE   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic             valid;
        pos_t             pos;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             frame;
    } issue_t;

endpackage

`default_nettype wire

FILE: rtl/nws_front.sv
`default_nettype none

module nws_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire nws_pkg::pix_t             pixel_in,
    input  wire logic [nws_pkg::WCFG_W-1:0] image_width,
    input  wire logic [nws_pkg::ROW_W-1:0]  image_height,
    input  wire logic                      advance,
    output nws_pkg::issue_t                issue,
    output nws_pkg::win_t                  window
);

    localparam int COL_W = nws_pkg::COL_W;
    localparam int ROW_W = nws_pkg::ROW_W;
    localparam int WCFG_W = nws_pkg::WCFG_W;

    nws_pkg::pix_t older_store [nws_pkg::MAX_WIDTH];
    nws_pkg::pix_t prev_store  [nws_pkg::MAX_WIDTH];

    nws_pkg::win_t win_reg;
    nws_pkg::win_t win_next;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [3:0]       mask_reg, mask_next;
    logic [COL_W-1:0] job_col_reg;
    logic [ROW_W-1:0] job_row_reg;

    logic [WCFG_W-1:0] w_eff;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic              last_col, last_row;
    logic [3:0]        new_mask;
    logic [3:0]        rem_mask;
    nws_pkg::pos_t     pos;
    logic              accept;

    always_comb
    begin
        if (image_width < WCFG_W'(2))
        begin
            w_eff = WCFG_W'(2);
        end
        else if (image_width > WCFG_W'(nws_pkg::MAX_WIDTH))
        begin
            w_eff = WCFG_W'(nws_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = image_width;
        end
        w_m1 = COL_W'(w_eff - WCFG_W'(1));
        h_m1 = (image_height < ROW_W'(2)) ? ROW_W'(1) : image_height - ROW_W'(1);

        c_cur    = (col_reg > w_m1) ? w_m1 : col_reg;
        r_cur    = (row_reg > h_m1) ? h_m1 : row_reg;
        last_col = (c_cur == w_m1);
        last_row = (r_cur == h_m1);

        new_mask[0] = (r_cur != '0) && (c_cur != '0);
        new_mask[1] = (r_cur != '0) && last_col;
        new_mask[2] = last_row && (c_cur != '0);
        new_mask[3] = last_row && last_col;
    end

    // lowest pending position goes first
    always_comb
    begin
        if (mask_reg[0])
        begin
            pos = nws_pkg::POS_PREV_LEFT;
        end
        else if (mask_reg[1])
        begin
            pos = nws_pkg::POS_PREV_HERE;
        end
        else if (mask_reg[2])
        begin
            pos = nws_pkg::POS_CUR_LEFT;
        end
        else
        begin
            pos = nws_pkg::POS_CUR_HERE;
        end
        rem_mask = mask_reg & ~(4'b0001 << pos);

        issue.valid = advance && (mask_reg != 4'b0000);
        issue.pos   = pos;
        issue.row   = pos[1] ? job_row_reg : job_row_reg - ROW_W'(1);
        issue.col   = pos[0] ? job_col_reg : job_col_reg - COL_W'(1);
        issue.last  = (rem_mask == 4'b0000);
        issue.frame = (pos == nws_pkg::POS_CUR_HERE);

        in_stall = !((mask_reg == 4'b0000) || (advance && (rem_mask == 4'b0000)));
        accept   = in_valid && !in_stall;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = (c_cur == '0) ? '0 : win_reg[i][1];
            win_next[i][1] = (c_cur == '0) ? '0 : win_reg[i][2];
        end
        win_next[0][2] = (r_cur >= ROW_W'(2)) ? older_store[c_cur] : '0;
        win_next[1][2] = (r_cur >= ROW_W'(1)) ? prev_store[c_cur] : '0;
        win_next[2][2] = pixel_in;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_cur + ROW_W'(1);
        end
        else
        begin
            col_next = c_cur + COL_W'(1);
            row_next = r_cur;
        end

        if (accept)
        begin
            mask_next = new_mask;
        end
        else if (issue.valid)
        begin
            mask_next = rem_mask;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            mask_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            mask_reg <= mask_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_store[c_cur] <= prev_store[c_cur];
            prev_store[c_cur]  <= pixel_in;
            job_col_reg        <= c_cur;
            job_row_reg        <= r_cur;
        end
    end

    assign window = win_reg;

`ifndef SYNTHESIS
    a_frame_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.frame |-> issue.last)
        else $error("frame-end result not last of its run");

    a_issue_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> advance)
        else $error("result issued into a stalled pipeline");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> col_reg <= $past(w_m1))
        else $error("column count past the row end");
`endif

endmodule

`default_nettype wire

FILE: rtl/nws_filter.sv
`default_nettype none

module nws_filter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire nws_pkg::issue_t             issue,
    input  wire nws_pkg::win_t               window,
    input  wire logic [nws_pkg::WGT_W-1:0]   corner_weight,
    input  wire logic [nws_pkg::WGT_W-1:0]   edge_weight,
    output logic                             advance,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output nws_pkg::pix_t                    pixel_out,
    output logic [nws_pkg::ROW_W-1:0]        out_row,
    output logic [nws_pkg::COL_W-1:0]        out_col,
    output logic                             last_of_run,
    output logic                             frame_done
);

    localparam int SUM_W  = nws_pkg::SUM_W;
    localparam int PROD_W = nws_pkg::PROD_W;
    localparam int ACC_W  = nws_pkg::ACC_W;
    localparam int PIX_W  = nws_pkg::PIX_W;
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(2 ** (nws_pkg::FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (PIX_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    nws_pkg::pix_t pp [4][4];
    logic [1:0]    ci, cj;

    logic signed [SUM_W-1:0]  diag_next, orth_next;
    logic signed [PROD_W-1:0] pd_next, po_next;
    logic signed [ACC_W-1:0]  acc, q;
    nws_pkg::pix_t            pix_next;

    // stage 1: neighbour sums, stage 2: products, stage 3: round and saturate
    logic                     s1_valid_reg, s2_valid_reg, out_valid_reg;
    nws_pkg::issue_t          s1_tag_reg, s2_tag_reg;
    logic signed [SUM_W-1:0]  s1_diag_reg, s1_orth_reg;
    logic signed [PROD_W-1:0] s2_pd_reg, s2_po_reg;
    nws_pkg::pix_t            out_pix_reg;
    logic [nws_pkg::ROW_W-1:0] out_row_reg;
    logic [nws_pkg::COL_W-1:0] out_col_reg;
    logic                     out_last_reg, out_frame_reg;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        // zero padding on the right column and bottom row of the patch
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pp[i][j] = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pp[i][j] = window[i][j];
            end
        end
        ci = issue.pos[1] ? 2'd2 : 2'd1;
        cj = issue.pos[0] ? 2'd2 : 2'd1;

        diag_next = SUM_W'(pp[ci - 2'd1][cj - 2'd1]) + SUM_W'(pp[ci - 2'd1][cj + 2'd1])
                  + SUM_W'(pp[ci + 2'd1][cj - 2'd1]) + SUM_W'(pp[ci + 2'd1][cj + 2'd1]);
        orth_next = SUM_W'(pp[ci - 2'd1][cj]) + SUM_W'(pp[ci + 2'd1][cj])
                  + SUM_W'(pp[ci][cj - 2'd1]) + SUM_W'(pp[ci][cj + 2'd1]);
    end

    always_comb
    begin
        pd_next = PROD_W'(s1_diag_reg) * PROD_W'($signed({1'b0, corner_weight}));
        po_next = PROD_W'(s1_orth_reg) * PROD_W'($signed({1'b0, edge_weight}));

        acc = ACC_W'(s2_pd_reg) + ACC_W'(s2_po_reg) + ROUND;
        q   = acc >>> nws_pkg::FRAC_W;
        if (q > SAT_HI)
        begin
            pix_next = PIX_W'(SAT_HI);
        end
        else if (q < SAT_LO)
        begin
            pix_next = PIX_W'(SAT_LO);
        end
        else
        begin
            pix_next = PIX_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= issue.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg    <= issue;
            s1_diag_reg   <= diag_next;
            s1_orth_reg   <= orth_next;
            s2_tag_reg    <= s1_tag_reg;
            s2_pd_reg     <= pd_next;
            s2_po_reg     <= po_next;
            out_pix_reg   <= pix_next;
            out_row_reg   <= s2_tag_reg.row;
            out_col_reg   <= s2_tag_reg.col;
            out_last_reg  <= s2_tag_reg.last;
            out_frame_reg <= s2_tag_reg.frame;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = out_pix_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last_of_run = out_last_reg;
    assign frame_done  = out_frame_reg;

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !advance |=> s2_valid_reg)
        else $error("pipeline dropped a result under stall");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_reg |-> out_last_reg)
        else $error("frame end without run end");

    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg |=> s2_valid_reg)
        else $error("stage 1 result lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/neighbour_weighted_stencil_3x3.sv
`default_nettype none

// 3x3 neighbour-weighted stencil with zero padding on a raster pixel stream
// (signed Q8.8). Each output is corner_weight times the four diagonal
// neighbours plus edge_weight times the four orthogonal ones, rounded half up
// and saturated to Q8.8; the centre pixel does not count. One pixel is taken
// per clock while every pixel yields at most one result and the output is not
// stalled; a row-end pixel below the first row yields two results and pixels
// of the last row yield up to four, and in_stall is raised while extra results
// remain, because all results share the single filter pipeline. The results of
// a pixel pass through the neighbour-sum, product and round-and-saturate stages,
// and each beat is flagged with its row, column, the last result of its input
// pixel and the frame end. Line stores hold two earlier rows of up to 32
// pixels. Register writes are taken at any clock (cfg_ready is always high)
// and must be made between frames.
module neighbour_weighted_stencil_3x3 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [15:0]          pixel_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [15:0]               pixel_out,
    output logic [15:0]                      out_row,
    output logic [4:0]                       out_col,
    output logic                             last_of_run,
    output logic                             frame_done,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [15:0]                 cfg_data
);

    logic [nws_pkg::WCFG_W-1:0] width_reg;
    logic [nws_pkg::ROW_W-1:0]  height_reg;
    logic [nws_pkg::WGT_W-1:0]  corner_reg;
    logic [nws_pkg::WGT_W-1:0]  edge_reg;

    nws_pkg::issue_t issue;
    nws_pkg::win_t   window;
    logic            advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nws_pkg::WCFG_W'(20);
            height_reg <= nws_pkg::ROW_W'(20);
            corner_reg <= nws_pkg::WGT_W'(6554);
            edge_reg   <= nws_pkg::WGT_W'(9830);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (nws_pkg::cfg_idx_t'(cfg_index))
                nws_pkg::REG_WIDTH:  width_reg  <= cfg_data[nws_pkg::WCFG_W-1:0];
                nws_pkg::REG_HEIGHT: height_reg <= cfg_data;
                nws_pkg::REG_CORNER: corner_reg <= cfg_data;
                nws_pkg::REG_EDGE:   edge_reg   <= cfg_data;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    nws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .image_width  (width_reg),
        .image_height (height_reg),
        .advance      (advance),
        .issue        (issue),
        .window       (window)
    );

    nws_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue         (issue),
        .window        (window),
        .corner_weight (corner_reg),
        .edge_weight   (edge_reg),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_out     (pixel_out),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_neighbour_weighted_stencil_3x3.sv
module tb_neighbour_weighted_stencil_3x3;

    import nws_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int RAND_ITEMS     = 370;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int NUM_DIRECTED   = 37;

    typedef struct packed {
        pix_t        pix;
        logic [15:0] row;
        logic [4:0]  col;
        logic        last;
        logic        frame;
    } stencil_res_t;

    typedef enum logic {
        STEP_CFG = 1'b0,
        STEP_PIX = 1'b1
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        cfg_idx_t    idx;
        logic [15:0] data;
        logic        fixed;
        logic [15:0] want;
    } step_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pix_t     pixel_in;
    logic     out_valid;
    logic     out_stall;
    pix_t     pixel_out;
    logic [15:0] out_row;
    logic [4:0]  out_col;
    logic     last_of_run;
    logic     frame_done;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    logic [15:0] cfg_data;

    // shadow of the block: registers, line stores, window, counters
    int     cfg_width  = 20;
    int     cfg_height = 20;
    int     corner_wt  = 6554;
    int     edge_wt    = 9830;
    pix_t   older_row [MAX_WIDTH];
    pix_t   prev_row [MAX_WIDTH];
    pix_t   win [3][3] = '{default: '0};
    longint patch [4][4];
    int     col_cnt = 0;
    int     row_cnt = 0;

    stencil_res_t pending_filtered [$];
    int  fail_count = 0;
    bit  no_idle    = 1'b0;
    bit  hold_off   = 1'b0;
    step_t directed [NUM_DIRECTED];

    neighbour_weighted_stencil_3x3 uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_done  (frame_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint neighbour_sum_at(int i, int j);
        longint diag;
        longint orth;
        longint q;
        diag = patch[i-1][j-1] + patch[i-1][j+1] + patch[i+1][j-1] + patch[i+1][j+1];
        orth = patch[i-1][j] + patch[i+1][j] + patch[i][j-1] + patch[i][j+1];
        // round half up, arithmetic shift floors
        q = (diag * longint'(corner_wt) + orth * longint'(edge_wt) + 32768) >>> FRAC_W;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q;
    endfunction

    function automatic void apply_stencil(input pix_t px, input bit fixed, input pix_t want);
        int w;
        int h;
        int c;
        int r;
        int n;
        bit lc;
        bit lr;
        stencil_res_t res [4];
        w = cfg_width < 2 ? 2 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
        h = cfg_height < 2 ? 2 : cfg_height;
        c = col_cnt > w - 1 ? w - 1 : col_cnt;
        r = row_cnt > h - 1 ? h - 1 : row_cnt;
        lc = (c == w - 1);
        lr = (r == h - 1);
        if (c == 0)
            win = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        // rows above the frame are zero, not store contents
        win[0][2] = r >= 2 ? older_row[c] : '0;
        win[1][2] = r >= 1 ? prev_row[c] : '0;
        win[2][2] = px;
        older_row[c] = prev_row[c];
        prev_row[c] = px;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                patch[i][j] = (i < 3 && j < 3) ? longint'(win[i][j]) : 0;
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            res[n] = '{pix_t'(neighbour_sum_at(1, 1)), 16'(r - 1), 5'(c - 1), 1'b0, 1'b0};
            n++;
        end
        if (r >= 1 && lc)
        begin
            res[n] = '{pix_t'(neighbour_sum_at(1, 2)), 16'(r - 1), 5'(c), 1'b0, 1'b0};
            n++;
        end
        if (lr && c >= 1)
        begin
            res[n] = '{pix_t'(neighbour_sum_at(2, 1)), 16'(r), 5'(c - 1), 1'b0, 1'b0};
            n++;
        end
        if (lr && lc)
        begin
            res[n] = '{pix_t'(neighbour_sum_at(2, 2)), 16'(r), 5'(c), 1'b0, 1'b1};
            n++;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if (fixed)
                res[k].pix = want;
            pending_filtered.push_back(res[k]);
        end
        if (lc)
        begin
            col_cnt = 0;
            row_cnt = lr ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        if (sel < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic pix_t rand_pixel();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return pix_t'($urandom);
        if (sel < 80)
            return sel[0] ? 16'sh7fff : 16'sh8000;
        if (sel < 90)
            return pix_t'($urandom_range(0, 1023) - 512);
        return sel[0] ? '0 : '1;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // leaves cfg_valid high so back-to-back writes need no extra edge
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_WIDTH:  cfg_width  = int'(data[WCFG_W-1:0]);
            REG_HEIGHT: cfg_height = int'(data);
            REG_CORNER: corner_wt  = int'(data);
            REG_EDGE:   edge_wt    = int'(data);
            default:    ;
        endcase
    endtask

    // in_valid stays high after a beat unless a gap follows
    task automatic send_pixel(input pix_t px, input bit fixed, input pix_t want);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (in_stall);
        apply_stencil(px, fixed, want);
    endtask

    // pixels with no result may still be in the window logic, hence the settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_filtered.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit prev_cfg;
        int sent;
        int phase;
        int sel;
        int w_reg;
        int h_reg;
        int frame_px;
        int eff_w;
        int eff_h;
        logic [15:0] wt;
        directed = '{
            // defaults for weights; width 0 and height 1 act as 2x2
            '{STEP_CFG, REG_WIDTH,  16'd0,     1'b0, 16'h0000},
            '{STEP_CFG, REG_HEIGHT, 16'd1,     1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h0001,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'hffff,  1'b0, 16'h0000},
            // full-scale weights saturate both ways
            '{STEP_CFG, REG_CORNER, 16'hffff,  1'b0, 16'h0000},
            '{STEP_CFG, REG_EDGE,   16'hffff,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h7fff},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h7fff},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h7fff},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h7fff},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b1, 16'h8000},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b1, 16'h8000},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b1, 16'h8000},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b1, 16'h8000},
            // zero weights
            '{STEP_CFG, REG_CORNER, 16'h0000,  1'b0, 16'h0000},
            '{STEP_CFG, REG_EDGE,   16'h0000,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b1, 16'h0000},
            // tall frame cut short: counters end up past the new size
            '{STEP_CFG, REG_WIDTH,  16'd3,     1'b0, 16'h0000},
            '{STEP_CFG, REG_HEIGHT, 16'hffff,  1'b0, 16'h0000},
            '{STEP_CFG, REG_CORNER, 16'd6554,  1'b0, 16'h0000},
            '{STEP_CFG, REG_EDGE,   16'd9830,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h0100,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'hff00,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h1234,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'hedcb,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h7fff,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h8000,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h0080,  1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'hfe80,  1'b0, 16'h0000},
            '{STEP_CFG, REG_HEIGHT, 16'd2,     1'b0, 16'h0000},
            '{STEP_CFG, REG_WIDTH,  16'd2,     1'b0, 16'h0000},
            '{STEP_PIX, REG_WIDTH,  16'h0300,  1'b0, 16'h0000}
        };
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        pixel_in  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        prev_cfg = 1'b1;
        foreach (directed[k])
        begin
            if (directed[k].kind == STEP_CFG)
            begin
                if (!prev_cfg)
                    wait_idle();
                write_reg(directed[k].idx, directed[k].data);
                prev_cfg = 1'b1;
            end
            else
            begin
                if (prev_cfg)
                    cfg_valid <= 1'b0;
                send_pixel(directed[k].data, directed[k].fixed, directed[k].want);
                prev_cfg = 1'b0;
            end
        end

        // random part: whole frames, config changed only between them
        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                case ($urandom_range(0, 3))
                    0: w_reg = 0;
                    1: w_reg = 1;
                    2: w_reg = 33;
                    default: w_reg = 63;
                endcase
            end
            else if (sel < 20)
                w_reg = $urandom_range(9, 32);
            else
                w_reg = $urandom_range(2, 6);
            h_reg = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 1) : $urandom_range(2, 4);
            case (phase)
                0:
                begin
                    w_reg = 63;
                    h_reg = 2;
                end
                1:
                begin
                    w_reg = 8;
                    h_reg = 3;
                end
                2:
                begin
                    w_reg = 16;
                    h_reg = 4;
                end
                3:
                begin
                    w_reg = 1;
                    h_reg = 0;
                end
                default: ;
            endcase
            wait_idle();
            write_reg(REG_WIDTH, 16'(w_reg));
            write_reg(REG_HEIGHT, 16'(h_reg));
            sel = $urandom_range(0, 99);
            wt  = sel < 15 ? 16'h0000 : (sel < 30 ? 16'hffff : 16'($urandom));
            write_reg(REG_CORNER, wt);
            sel = $urandom_range(0, 99);
            wt  = sel < 15 ? 16'h0000 : (sel < 30 ? 16'hffff : 16'($urandom));
            write_reg(REG_EDGE, wt);
            cfg_valid <= 1'b0;
            no_idle = (phase == 1);
            if (phase == 2)
                hold_off = 1'b1;
            eff_w    = cfg_width < 2 ? 2 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
            eff_h    = cfg_height < 2 ? 2 : cfg_height;
            frame_px = eff_w * eff_h;
            repeat (frame_px)
            begin
                send_pixel(rand_pixel(), 1'b0, '0);
                sent++;
            end
            phase++;
        end
        no_idle = 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("tb_neighbour_weighted_stencil_3x3 OK");
        else
            $display("tb_neighbour_weighted_stencil_3x3 NOT OK");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin : sink
        int sel;
        int len;
        bit val;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                val = 1'b1;
                if (no_idle || sel < 55)
                begin
                    val = 1'b0;
                    len = $urandom_range(1, 24);
                end
                else if (sel < 88)
                    len = $urandom_range(1, 3);
                else if (sel < 97)
                    len = $urandom_range(4, 12);
                else
                    len = $urandom_range(20, 60);
                out_stall <= val;
                repeat (len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        stencil_res_t head;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_filtered.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: pixel_out %0d row %0d col %0d",
                         $time, pixel_out, out_row, out_col);
                fail_count++;
            end
            else
            begin
                head = pending_filtered.pop_front();
                check_field("pixel_out", head.pix, pixel_out);
                check_field("out_row", head.row, out_row);
                check_field("out_col", head.col, out_col);
                check_field("last_of_run", head.last, last_of_run);
                check_field("frame_done", head.frame, frame_done);
            end
        end
    end

    initial
    begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_neighbour_weighted_stencil_3x3 NOT OK");
        $finish;
    end

endmodule
